### design/fmbq_pkg.sv
// ---------------------------------------------------------------------------
// fmbq_pkg: shared types and constants for the front/middle/back queue
// Operation codes, status codes, widths and the store command structure.
// ---------------------------------------------------------------------------
package fmbq_pkg;

    // Number of entries the queue holds
    localparam int CAPACITY = 32;

    // Field widths
    localparam int FUNC_W = 3;
    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int OCC_W  = 6;

    // Store position and fill count widths
    localparam int POS_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Value returned by a pop on an empty queue
    localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

    // Operation codes
    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH_FRONT  = 3'd0,
        FN_PUSH_MIDDLE = 3'd1,
        FN_PUSH_BACK   = 3'd2,
        FN_POP_FRONT   = 3'd3,
        FN_POP_MIDDLE  = 3'd4,
        FN_POP_BACK    = 3'd5
    } t_func;

    // Result status codes
    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Command to the ordered store: insert or remove at one position
    typedef struct packed {
        logic              ins;
        logic              rem;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] value;
    } t_store_cmd;

endpackage

### design/front_middle_back_queue.sv
// ---------------------------------------------------------------------------
// front_middle_back_queue: bounded queue with front, middle and back access
// Push or pop at the front, middle or back of an ordered store of
// fmbq_pkg::CAPACITY entries; each operation returns one result.
// ---------------------------------------------------------------------------
//
//  Channel  | Handshake                  | Payload
//  ---------+----------------------------+-----------------------------------
//  input    | i_in_valid / o_in_ready    | i_func, i_push_value
//  output   | o_out_valid / i_out_ready  | o_pop_value, o_status, o_occupancy
//
//  One operation per cycle unless a held result stalls the input: the store
//  update and the result are formed in the cycle the transaction is accepted
//  and the result is registered, valid in the cycle after input acceptance.
//  A stalled result holds the output register; input is taken again in the
//  same cycle the held result is taken.
//  Reset clears the fill count and the output valid; the store needs no
//  clearing since only entries below the fill count are read.
// ---------------------------------------------------------------------------
module front_middle_back_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fmbq_pkg::FUNC_W-1:0]   i_func,
    input  logic signed [fmbq_pkg::DATA_W-1:0] i_push_value,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic signed [fmbq_pkg::DATA_W-1:0] o_pop_value,
    output logic [fmbq_pkg::STAT_W-1:0]   o_status,
    output logic [fmbq_pkg::OCC_W-1:0]    o_occupancy
);

    localparam logic [fmbq_pkg::CNT_W-1:0] CNT_FULL = fmbq_pkg::CNT_W'(fmbq_pkg::CAPACITY);

    logic [fmbq_pkg::CNT_W-1:0]  r_count, n_count;
    logic                        r_out_valid;
    logic [fmbq_pkg::DATA_W-1:0] r_pop_value, n_pop_value;
    fmbq_pkg::t_status           r_status, n_status;
    logic [fmbq_pkg::OCC_W-1:0]  r_occ;
    fmbq_pkg::t_store_cmd        w_cmd;
    logic [fmbq_pkg::DATA_W-1:0] w_rd_data;
    logic [fmbq_pkg::CNT_W-1:0]  w_last;
    logic                        w_accept;
    logic                        w_pop_ok;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_last     = r_count - fmbq_pkg::CNT_W'(1);

    // Decode the operation against the current fill count
    always_comb begin
        w_cmd       = '0;
        w_cmd.value = i_push_value;
        n_count     = r_count;
        n_pop_value = '0;
        n_status    = fmbq_pkg::ST_DONE;
        w_pop_ok    = 1'b0;
        unique case (fmbq_pkg::t_func'(i_func))
            fmbq_pkg::FN_PUSH_FRONT,
            fmbq_pkg::FN_PUSH_MIDDLE,
            fmbq_pkg::FN_PUSH_BACK: begin
                if (r_count >= CNT_FULL) begin
                    n_status = fmbq_pkg::ST_FULL;
                end else begin
                    w_cmd.ins = w_accept;
                    n_count   = r_count + fmbq_pkg::CNT_W'(1);
                    if (fmbq_pkg::t_func'(i_func) == fmbq_pkg::FN_PUSH_MIDDLE) begin
                        w_cmd.pos = fmbq_pkg::POS_W'(r_count >> 1);
                    end else if (fmbq_pkg::t_func'(i_func) == fmbq_pkg::FN_PUSH_BACK) begin
                        w_cmd.pos = fmbq_pkg::POS_W'(r_count);
                    end
                end
            end
            fmbq_pkg::FN_POP_FRONT,
            fmbq_pkg::FN_POP_MIDDLE,
            fmbq_pkg::FN_POP_BACK: begin
                if (r_count == '0) begin
                    n_pop_value = fmbq_pkg::EMPTY_VALUE;
                    n_status    = fmbq_pkg::ST_EMPTY;
                end else begin
                    w_cmd.rem = w_accept;
                    n_count   = w_last;
                    if (fmbq_pkg::t_func'(i_func) == fmbq_pkg::FN_POP_MIDDLE) begin
                        w_cmd.pos = fmbq_pkg::POS_W'(w_last >> 1);
                    end else if (fmbq_pkg::t_func'(i_func) == fmbq_pkg::FN_POP_BACK) begin
                        w_cmd.pos = fmbq_pkg::POS_W'(w_last);
                    end
                    w_pop_ok = 1'b1;
                end
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    fmbq_store u_store (
        .i_clk     (i_clk),
        .i_cmd     (w_cmd),
        .o_rd_data (w_rd_data)
    );

    // Advance the fill count and the output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the result payload; a successful pop takes the addressed entry
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pop_value <= w_pop_ok ? w_rd_data : n_pop_value;
            r_status    <= n_status;
            r_occ       <= fmbq_pkg::OCC_W'(n_count);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_pop_value = r_pop_value;
    assign o_status    = r_status;
    assign o_occupancy = r_occ;

`ifndef SYNTH
    // Fill count never passes the capacity
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_FULL)
        else $error("fill count beyond capacity");

    // An accepted transaction always yields a result next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> o_out_valid)
        else $error("accepted transaction without result");

    // Fill count moves only on an accepted transaction
    a_count_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_accept |=> $stable(r_count))
        else $error("fill count changed without a transaction");

    // A refused push reports a full queue
    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == fmbq_pkg::ST_FULL) |->
            (r_count == CNT_FULL))
        else $error("full status with room left");

    // An empty pop reports all ones and nothing held
    a_empty_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && r_status == fmbq_pkg::ST_EMPTY) |->
            (r_pop_value == fmbq_pkg::EMPTY_VALUE && r_occ == '0))
        else $error("empty status with bad payload");
`endif

endmodule

### design/fmbq_store.sv
// ---------------------------------------------------------------------------
// fmbq_store: ordered entry store
// A row of entry registers kept in order from the front. An insert opens a
// gap at the given position by shifting later entries back by one; a remove
// closes the gap by shifting later entries forward. The entry at the given
// position is read out before the update.
// ---------------------------------------------------------------------------
module fmbq_store (
    input  logic                         i_clk,
    input  fmbq_pkg::t_store_cmd         i_cmd,
    output logic [fmbq_pkg::DATA_W-1:0]  o_rd_data
);

    logic [fmbq_pkg::DATA_W-1:0] r_slot [fmbq_pkg::CAPACITY];
    logic [fmbq_pkg::DATA_W-1:0] n_slot [fmbq_pkg::CAPACITY];

    // Read the addressed entry
    assign o_rd_data = r_slot[i_cmd.pos];

    // Each cell picks hold, write, or a neighbor
    for (genvar g = 0; g < fmbq_pkg::CAPACITY; g++) begin : g_cell
        localparam logic [fmbq_pkg::POS_W-1:0] IDX = fmbq_pkg::POS_W'(g);

        always_comb begin
            n_slot[g] = r_slot[g];
            if (i_cmd.ins) begin
                if (IDX == i_cmd.pos) begin
                    n_slot[g] = i_cmd.value;
                end else if (IDX > i_cmd.pos) begin
                    if (g > 0) begin
                        n_slot[g] = r_slot[(g > 0) ? g - 1 : 0];
                    end
                end
            end else if (i_cmd.rem) begin
                if (IDX >= i_cmd.pos) begin
                    if (g < fmbq_pkg::CAPACITY - 1) begin
                        n_slot[g] = r_slot[(g < fmbq_pkg::CAPACITY - 1) ? g + 1 : g];
                    end
                end
            end
        end

        always_ff @(posedge i_clk) begin
            r_slot[g] <= n_slot[g];
        end
    end

endmodule

### verif/front_middle_back_queue_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// front_middle_back_queue_tb: self-checking bench for the front/middle/back queue
// A driver feeds push and pop operations from a pending list. A monitor keeps
// a shadow copy of the ordered store, predicts every result and compares it
// field by field. Both handshakes idle in random bursts, and once the output
// holds off long enough to stall the input.
// ---------------------------------------------------------------------------
module front_middle_back_queue_tb;
    import fmbq_pkg::*;

    localparam int CLK_PERIOD     = 8;
    localparam int RESET_CYCLES   = 12;
    localparam int RANDOM_OPS     = 1450;
    localparam int SEG_LEN        = 50;
    localparam int CALM_TAIL      = 150;
    localparam int QUIET_HI       = 850;
    localparam int QUIET_LO       = 700;
    localparam int HOLD_AT        = 400;
    localparam int HOLD_CYCLES    = 120;
    localparam int DRAIN_CYCLES   = 10;
    localparam int TIMEOUT_CYCLES = 500_000;

    // Codes outside the operation set; the block must leave the store alone
    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam int PUSH_MIX [5] = '{10, 35, 50, 65, 92};

    typedef struct {
        logic [FUNC_W-1:0]        fn;
        logic signed [DATA_W-1:0] value;
    } t_queue_op;

    typedef struct packed {
        logic signed [DATA_W-1:0] pop_value;
        logic [STAT_W-1:0]        status;
        logic [OCC_W-1:0]         occupancy;
    } t_queue_result;

    logic                     i_clk        = 1'b0;
    logic                     i_rst_n      = 1'b0;
    logic                     i_in_valid   = 1'b0;
    logic [FUNC_W-1:0]        i_func       = '0;
    logic signed [DATA_W-1:0] i_push_value = '0;
    logic                     i_out_ready  = 1'b0;
    logic                     o_in_ready;
    logic                     o_out_valid;
    logic signed [DATA_W-1:0] o_pop_value;
    logic [STAT_W-1:0]        o_status;
    logic [OCC_W-1:0]         o_occupancy;

    t_queue_op                pending_ops[$];
    t_queue_result            expected_results[$];
    logic signed [DATA_W-1:0] shadow_q[$];

    logic in_took      = 1'b0;
    int   taken_ops    = 0;
    int   mismatch_count = 0;
    int   gap_left     = 0;
    int   stall_left   = 0;
    int   hold_left    = 0;
    bit   hold_done    = 1'b0;

    front_middle_back_queue dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_func       (i_func),
        .i_push_value (i_push_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_pop_value  (o_pop_value),
        .o_status     (o_status),
        .o_occupancy  (o_occupancy)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Apply one operation to the shadow store and form its result
    function automatic t_queue_result apply_op(input logic [FUNC_W-1:0] fn,
                                               input logic signed [DATA_W-1:0] value);
        t_queue_result res;
        int            n;
        n = shadow_q.size();
        res.pop_value = '0;
        res.status    = ST_DONE;
        case (fn)
            FN_PUSH_FRONT, FN_PUSH_MIDDLE, FN_PUSH_BACK: begin
                if (n >= CAPACITY) begin
                    res.status = ST_FULL;
                end else if (fn == FN_PUSH_FRONT) begin
                    shadow_q.insert(0, value);
                end else if (fn == FN_PUSH_MIDDLE) begin
                    shadow_q.insert(n / 2, value);
                end else begin
                    shadow_q.insert(n, value);
                end
            end
            FN_POP_FRONT, FN_POP_MIDDLE, FN_POP_BACK: begin
                if (n == 0) begin
                    res.pop_value = EMPTY_VALUE;
                    res.status    = ST_EMPTY;
                end else if (fn == FN_POP_FRONT) begin
                    res.pop_value = shadow_q[0];
                    shadow_q.delete(0);
                end else if (fn == FN_POP_MIDDLE) begin
                    res.pop_value = shadow_q[(n - 1) / 2];
                    shadow_q.delete((n - 1) / 2);
                end else begin
                    res.pop_value = shadow_q[n - 1];
                    shadow_q.delete(n - 1);
                end
            end
            default: begin
            end
        endcase
        res.occupancy = OCC_W'(shadow_q.size());
        return res;
    endfunction

    task automatic add_op(input logic [FUNC_W-1:0] fn, input logic signed [DATA_W-1:0] value);
        t_queue_op op;
        op.fn    = fn;
        op.value = value;
        pending_ops.insert(pending_ops.size(), op);
    endtask

    // Driver: present pending transactions, hold until taken, idle in bursts
    always @(negedge i_clk) begin
        t_queue_op op;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_took) begin
            // hold the current transaction
        end else if (gap_left > 0) begin
            i_in_valid <= 1'b0;
            gap_left--;
        end else if (pending_ops.size() != 0) begin
            op = pending_ops[0];
            pending_ops.delete(0);
            i_func       <= op.fn;
            i_push_value <= op.value;
            i_in_valid   <= 1'b1;
            if (pending_ops.size() >= CALM_TAIL
                    && !(pending_ops.size() >= QUIET_LO && pending_ops.size() < QUIET_HI)
                    && $urandom_range(0, 3) == 0) begin
                gap_left = $urandom_range(1, 14);
            end
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // Receiver: random stalls, plus one long hold-off to back up the input
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            i_out_ready <= 1'b0;
            hold_left--;
        end else if (!hold_done && taken_ops >= HOLD_AT) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            i_out_ready <= 1'b0;
        end else if (stall_left > 0) begin
            i_out_ready <= 1'b0;
            stall_left--;
        end else if (pending_ops.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(1, 14) - 1;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor: check taken results, then predict for the taken operation
    always @(posedge i_clk) begin
        t_queue_result want;
        if (!i_rst_n) begin
            in_took <= 1'b0;
        end else begin
            in_took <= i_in_valid && o_in_ready;
            if (o_out_valid && i_out_ready) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: pop_value %0d status %0d occupancy %0d",
                           o_pop_value, o_status, o_occupancy);
                    mismatch_count++;
                end else begin
                    want = expected_results[0];
                    expected_results.delete(0);
                    if (o_pop_value !== want.pop_value) begin
                        $error("pop_value: expected %0d, actual %0d", want.pop_value, o_pop_value);
                        mismatch_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, o_status);
                        mismatch_count++;
                    end
                    if (o_occupancy !== want.occupancy) begin
                        $error("occupancy: expected %0d, actual %0d",
                               want.occupancy, o_occupancy);
                        mismatch_count++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                expected_results.insert(expected_results.size(),
                                        apply_op(i_func, i_push_value));
                taken_ops++;
            end
        end
    end

    // Stimulus, reset and end of run
    initial begin
        int                       push_pct;
        int                       pick;
        logic [FUNC_W-1:0]        fn;
        logic signed [DATA_W-1:0] value;

        // Pops on an empty queue, then pushes at every position
        add_op(FN_POP_FRONT, 32'sd7);
        add_op(FN_POP_MIDDLE, VAL_MAX);
        add_op(FN_POP_BACK, VAL_MIN);
        add_op(FN_PUSH_MIDDLE, VAL_MIN);
        add_op(FN_PUSH_FRONT, VAL_MAX);
        add_op(FN_PUSH_BACK, -32'sd1);
        add_op(FN_PUSH_MIDDLE, 32'sd0);
        add_op(FN_PUSH_MIDDLE, 32'sh5555_5555);
        add_op(FN_PUSH_FRONT, 32'shAAAA_AAAA);
        // Unused codes must not disturb the store
        add_op(FN_UNUSED_6, -32'sd1);
        add_op(FN_UNUSED_7, 32'sd0);
        // Drain through every pop kind, then pop past empty
        add_op(FN_POP_MIDDLE, 32'sd0);
        add_op(FN_POP_FRONT, 32'sd0);
        add_op(FN_POP_BACK, 32'sd0);
        add_op(FN_POP_MIDDLE, 32'sd0);
        add_op(FN_POP_MIDDLE, 32'sd0);
        add_op(FN_POP_MIDDLE, 32'sd0);
        add_op(FN_POP_BACK, 32'sd0);

        // Random segments with a varying push share so the store swings
        // between empty and full
        for (int seg = 0; seg < RANDOM_OPS / SEG_LEN; seg++) begin
            push_pct = PUSH_MIX[$urandom_range(0, 4)];
            for (int k = 0; k < SEG_LEN; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 3) begin
                    fn = ($urandom_range(0, 1) != 0) ? FN_UNUSED_7 : FN_UNUSED_6;
                end else if (pick < 3 + push_pct * 97 / 100) begin
                    fn = FUNC_W'($urandom_range(FN_PUSH_FRONT, FN_PUSH_BACK));
                end else begin
                    fn = FUNC_W'($urandom_range(FN_POP_FRONT, FN_POP_BACK));
                end
                case ($urandom_range(0, 11))
                    0:       value = VAL_MIN;
                    1:       value = VAL_MAX;
                    2:       value = -32'sd1;
                    3:       value = 32'sd0;
                    default: value = $urandom;
                endcase
                add_op(fn, value);
            end
        end

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for the input side to empty, then for every result
        @(negedge i_clk);
        while (pending_ops.size() != 0 || i_in_valid) @(negedge i_clk);
        while (expected_results.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (expected_results.size() != 0) begin
            $error("%0d expected results never arrived", expected_results.size());
            mismatch_count++;
        end
        if (mismatch_count == 0) begin
            $display("** front_middle_back_queue: PASSED **");
        end else begin
            $display("** front_middle_back_queue: FAILED **");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(TIMEOUT_CYCLES * CLK_PERIOD);
        $display("** front_middle_back_queue: FAILED **");
        $finish;
    end

endmodule
